// ===== rtl/crc_codeword_checker_defines.svh =====
// crc_codeword_checker_defines.svh: assertion macros for the crc codeword checker
// expects signals clk and rst in the scope where a macro is used
// no other dependencies
`ifndef CRC_CODEWORD_CHECKER_DEFINES_SVH
`define CRC_CODEWORD_CHECKER_DEFINES_SVH

// condition holds at every edge outside reset
`define CRCCHK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define CRCCHK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/crcchk_pkg.sv =====
// crcchk_pkg: shared types and fixed constants of the crc codeword checker
// used by every module of the block; no dependencies

package crcchk_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NarrowDw = 4;
  localparam int unsigned WideDw   = 8;
  localparam int unsigned StatW    = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GEN_POLY = 2'd0,
    REG_GEN_LEN  = 2'd1,
    REG_WIDE_DW  = 2'd2
  } cfg_reg_t;

  // which codewords one data byte completes
  typedef struct packed {
    logic first_done;
    logic second_done;
  } unpack_flags_t;

  // check outcome of one codeword
  typedef struct packed {
    logic            bad;
    logic [ByteW-1:0] dataword;
  } div_res_t;

  // one result word as it leaves the block
  typedef struct packed {
    logic             codeword_bad;
    logic [ByteW-1:0] dataword_value;
    logic             byte_ready;
    logic [ByteW-1:0] decoded_byte;
    logic [StatW-1:0] words_seen;
    logic [StatW-1:0] errors_seen;
    logic             run_last;
  } result_t;

endpackage

// ===== rtl/crcchk_unpack.sv =====
// crcchk_unpack: splits one data byte against the held bits into up to two codewords
// depends on crcchk_pkg

module crcchk_unpack #(
  parameter int unsigned MAX_GEN_BITS = 16,
  localparam int unsigned CW_W = MAX_GEN_BITS + 7,
  localparam int unsigned ACC_W = MAX_GEN_BITS + 6,
  localparam int unsigned CL_W = $clog2(CW_W + 1),
  localparam int unsigned HW = $clog2(ACC_W + 9)
) (
  input  logic [ACC_W-1:0]              acc,
  input  logic [HW-1:0]                 held,
  input  logic [2:0]                    pad,
  input  logic [crcchk_pkg::ByteW-1:0]  data_byte,
  input  logic [CL_W-1:0]               cw_len,
  output logic [CW_W-1:0]               cw_first,
  output logic [CW_W-1:0]               cw_second,
  output crcchk_pkg::unpack_flags_t     flags,
  output logic [ACC_W-1:0]              acc_next,
  output logic [HW-1:0]                 held_next
);

  localparam int unsigned KW = HW + 1;

  logic [3:0]                            nb;
  logic [KW-1:0]                         held_k, len_k, nb_k, k1, k2, left;
  logic [ACC_W+crcchk_pkg::ByteW-1:0]    full, full_sh;
  logic [crcchk_pkg::ByteW-1:0]          byte_sh, keep, fresh;
  logic [CW_W-1:0]                       len_mask;

  always_comb begin
    // bits of this byte that count, MSB first
    nb     = 4'd8 - {1'b0, pad};
    held_k = KW'(held);
    len_k  = KW'(cw_len);
    nb_k   = KW'(nb);

    // new bits consumed up to each codeword end
    k1 = (held_k >= len_k) ? KW'(1) : len_k - held_k;
    k2 = k1 + len_k;
    flags.first_done  = (k1 <= nb_k);
    flags.second_done = flags.first_done && (k2 <= nb_k);

    // codeword windows
    len_mask  = ~({CW_W{1'b1}} << cw_len);
    full      = {acc, data_byte};
    full_sh   = full >> (nb_k - k1);
    cw_first  = full_sh[CW_W-1:0] & len_mask;
    byte_sh   = data_byte >> (nb_k - k2);
    cw_second = CW_W'(byte_sh) & len_mask;

    // bits left over after the last codeword
    if (flags.second_done) begin
      left = nb_k - k2;
    end else if (flags.first_done) begin
      left = nb_k - k1;
    end else begin
      left = held_k + nb_k;
    end
    keep  = ~(8'hFF << left);
    fresh = data_byte & ~(8'hFF << nb);

    if (flags.first_done) begin
      acc_next = ACC_W'(data_byte & keep);
    end else begin
      acc_next = (acc << nb) | ACC_W'(fresh);
    end
    held_next = HW'(left);
  end

endmodule

// ===== rtl/crcchk_divider.sv =====
// crcchk_divider: modulo-2 remainder check and dataword extraction for one codeword
// depends on crcchk_pkg

module crcchk_divider #(
  parameter int unsigned MAX_GEN_BITS = 16,
  localparam int unsigned CW_W = MAX_GEN_BITS + 7,
  localparam int unsigned CL_W = $clog2(CW_W + 1),
  localparam int unsigned GL_W = $clog2(MAX_GEN_BITS + 1)
) (
  input  logic [CW_W-1:0]         codeword,
  input  logic [CL_W-1:0]         cw_len,
  input  logic [GL_W-1:0]         gen_len,
  input  logic [MAX_GEN_BITS-1:0] gen,
  input  logic                    wide,
  output crcchk_pkg::div_res_t    res
);

  logic [CW_W-1:0] aligned, gen_top, rem, keep;
  logic [3:0]      dsize;

  always_comb begin
    dsize = wide ? 4'(crcchk_pkg::WideDw) : 4'(crcchk_pkg::NarrowDw);

    // left-align codeword and generator so the division steps sit at fixed bits
    aligned = codeword << (CL_W'(CW_W) - cw_len);
    gen_top = CW_W'(gen) << (CL_W'(CW_W) - CL_W'(gen_len));

    // one step per dataword bit
    rem = aligned;
    for (int i = 0; i < crcchk_pkg::WideDw; i++) begin
      if ((i < dsize) && rem[CW_W-1-i]) begin
        rem = rem ^ (gen_top >> i);
      end
    end

    // remainder is everything below the dataword positions
    keep      = {CW_W{1'b1}} >> dsize;
    res.bad   = |(rem & keep);
    res.dataword = wide ? aligned[CW_W-1 -: 8] : {4'b0000, aligned[CW_W-1 -: 4]};
  end

endmodule

// ===== rtl/crcchk_result_fifo.sv =====
// crcchk_result_fifo: four-word result queue, takes up to two words per cycle
// depends on crcchk_pkg

module crcchk_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_cnt,
  input  crcchk_pkg::result_t push_first,
  input  crcchk_pkg::result_t push_second,
  input  logic                pop,
  output crcchk_pkg::result_t head,
  output logic [2:0]          count
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  crcchk_pkg::result_t mem [Depth];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;

  // storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= push_second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_cnt);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + 3'(push_cnt) - 3'(pop);
    end
  end

  assign head = mem[rd_ptr];

endmodule

// ===== rtl/crc_codeword_checker.sv =====
// crc_codeword_checker: byte stream unpacker and crc checker, top level
// depends on crcchk_pkg, crcchk_unpack, crcchk_divider, crcchk_result_fifo
// and crc_codeword_checker_defines.svh
//
// Accepts one stream byte per clock when not stalled. A byte sits in the input
// register, where a single pass of unpacking and two remainder units settle it,
// and its results enter a four-word queue that drives the output. A data byte
// yields zero, one or two result words and the output side delivers one word per
// cycle while m_axis_tready is high, so bytes that complete two codewords outpace
// the output; the queue absorbs this and the input stalls only while the queue
// holds more than two words. Header bytes produce no word. Configuration writes
// take effect at once and are meant for idle periods.

`include "crc_codeword_checker_defines.svh"

module crc_codeword_checker #(
  parameter int unsigned MAX_GEN_BITS = 16,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] stream_byte
  input  logic [0:0]                        s_axis_tuser,  // [0] is_header
  // master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] dataword_value, [15:8] decoded_byte, [31:16] words_seen, [47:32] errors_seen
  output logic [47:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // [0] codeword_bad, [1] byte_ready
  output logic                              m_axis_tlast,  // run_last
  // configuration
  input  logic                              cfg_we,
  input  logic [crcchk_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [crcchk_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int unsigned CW_W  = MAX_GEN_BITS + 7;
  localparam int unsigned ACC_W = MAX_GEN_BITS + 6;
  localparam int unsigned CL_W  = $clog2(CW_W + 1);
  localparam int unsigned HW    = $clog2(ACC_W + 9);
  localparam int unsigned GL_W  = $clog2(MAX_GEN_BITS + 1);

  typedef struct packed {
    logic       byte_ready;
    logic [7:0] decoded;
    logic       waiting;
    logic [3:0] high;
  } pair_t;

  // configuration registers
  logic [15:0] generator_poly;
  logic [4:0]  generator_length;
  logic        wide_dataword;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_hdr;

  // unpacking and pairing state
  logic [ACC_W-1:0]      acc;
  logic [HW-1:0]         held;
  logic [2:0]            pad;
  logic [3:0]            high_nib;
  logic                  nib_wait;
  logic [COUNT_BITS-1:0] word_cnt, err_cnt;

  // derived configuration
  logic [GL_W-1:0]            glen;
  logic [CL_W-1:0]            cw_len;
  logic [MAX_GEN_BITS+15:0]   gp_ext;
  logic [MAX_GEN_BITS-1:0]    gen;

  // datapath
  logic [CW_W-1:0]            cw_first, cw_second;
  crcchk_pkg::unpack_flags_t  flags;
  logic [ACC_W-1:0]           acc_next;
  logic [HW-1:0]              held_next;
  crcchk_pkg::div_res_t       div0, div1;
  pair_t                      p0, p1;
  logic [COUNT_BITS-1:0]      w0, w1, e0, e1;
  crcchk_pkg::result_t        res0, res1, head;
  logic [1:0]                 push_cnt;
  logic [2:0]                 fifo_count;
  logic                       commit;
  logic                       pop;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt,
                                                   input logic en);
    return (en && (cnt != {COUNT_BITS{1'b1}})) ? cnt + COUNT_BITS'(1) : cnt;
  endfunction

  function automatic logic [15:0] stat16(input logic [COUNT_BITS-1:0] cnt);
    logic [COUNT_BITS+15:0] ext;
    ext = {16'b0, cnt};
    return ext[15:0];
  endfunction

  function automatic pair_t pair_nibble(input logic wide, input logic waiting,
                                        input logic [3:0] high, input logic [7:0] dw);
    pair_t p;
    p.high = high;
    if (wide) begin
      p.byte_ready = 1'b1;
      p.decoded    = dw;
      p.waiting    = 1'b0;
    end else if (waiting) begin
      p.byte_ready = 1'b1;
      p.decoded    = {high, dw[3:0]};
      p.waiting    = 1'b0;
      p.high       = 4'h0;
    end else begin
      p.byte_ready = 1'b0;
      p.decoded    = 8'h00;
      p.waiting    = 1'b1;
      p.high       = dw[3:0];
    end
    return p;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      generator_poly   <= 16'd7;
      generator_length <= 5'd3;
      wide_dataword    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        crcchk_pkg::REG_GEN_POLY: generator_poly   <= cfg_data;
        crcchk_pkg::REG_GEN_LEN:  generator_length <= cfg_data[4:0];
        crcchk_pkg::REG_WIDE_DW:  wide_dataword    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp generator length, mask generator, codeword length
  always_comb begin
    if (generator_length < 5'd2) begin
      glen = GL_W'(2);
    end else if (32'(generator_length) > MAX_GEN_BITS) begin
      glen = GL_W'(MAX_GEN_BITS);
    end else begin
      glen = GL_W'(generator_length);
    end
    cw_len = CL_W'(glen) - CL_W'(1) +
             (wide_dataword ? CL_W'(crcchk_pkg::WideDw) : CL_W'(crcchk_pkg::NarrowDw));
    gp_ext = {{MAX_GEN_BITS{1'b0}}, generator_poly};
    gen    = gp_ext[MAX_GEN_BITS-1:0] & ~({MAX_GEN_BITS{1'b1}} << glen);
  end

  // input handshake
  assign commit        = in_valid && (fifo_count <= 3'd2);
  assign s_axis_tready = !in_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (commit) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_hdr  <= s_axis_tuser[0];
    end
  end

  crcchk_unpack #(.MAX_GEN_BITS(MAX_GEN_BITS)) u_unpack (
    .acc       (acc),
    .held      (held),
    .pad       (pad),
    .data_byte (in_byte),
    .cw_len    (cw_len),
    .cw_first  (cw_first),
    .cw_second (cw_second),
    .flags     (flags),
    .acc_next  (acc_next),
    .held_next (held_next)
  );

  crcchk_divider #(.MAX_GEN_BITS(MAX_GEN_BITS)) u_div0 (
    .codeword (cw_first),
    .cw_len   (cw_len),
    .gen_len  (glen),
    .gen      (gen),
    .wide     (wide_dataword),
    .res      (div0)
  );

  crcchk_divider #(.MAX_GEN_BITS(MAX_GEN_BITS)) u_div1 (
    .codeword (cw_second),
    .cw_len   (cw_len),
    .gen_len  (glen),
    .gen      (gen),
    .wide     (wide_dataword),
    .res      (div1)
  );

  // nibble pairing and counters, second codeword follows the first
  always_comb begin
    p0 = pair_nibble(wide_dataword, nib_wait, high_nib, div0.dataword);
    p1 = pair_nibble(wide_dataword, p0.waiting, p0.high, div1.dataword);
    w0 = sat_inc(word_cnt, 1'b1);
    e0 = sat_inc(err_cnt, div0.bad);
    w1 = sat_inc(w0, 1'b1);
    e1 = sat_inc(e0, div1.bad);

    res0.codeword_bad   = div0.bad;
    res0.dataword_value = div0.dataword;
    res0.byte_ready     = p0.byte_ready;
    res0.decoded_byte   = p0.decoded;
    res0.words_seen     = stat16(w0);
    res0.errors_seen    = stat16(e0);
    res0.run_last       = !flags.second_done;

    res1.codeword_bad   = div1.bad;
    res1.dataword_value = div1.dataword;
    res1.byte_ready     = p1.byte_ready;
    res1.decoded_byte   = p1.decoded;
    res1.words_seen     = stat16(w1);
    res1.errors_seen    = stat16(e1);
    res1.run_last       = 1'b1;

    if (!commit || in_hdr) begin
      push_cnt = 2'd0;
    end else if (flags.second_done) begin
      push_cnt = 2'd2;
    end else if (flags.first_done) begin
      push_cnt = 2'd1;
    end else begin
      push_cnt = 2'd0;
    end
  end

  // state update once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      held     <= '0;
      pad      <= '0;
      high_nib <= '0;
      nib_wait <= 1'b0;
      word_cnt <= '0;
      err_cnt  <= '0;
    end else if (commit) begin
      if (in_hdr) begin
        pad      <= in_byte[2:0];
        acc      <= '0;
        held     <= '0;
        high_nib <= '0;
        nib_wait <= 1'b0;
      end else begin
        pad  <= '0;
        acc  <= acc_next;
        held <= held_next;
        if (flags.second_done) begin
          high_nib <= p1.high;
          nib_wait <= p1.waiting;
          word_cnt <= w1;
          err_cnt  <= e1;
        end else if (flags.first_done) begin
          high_nib <= p0.high;
          nib_wait <= p0.waiting;
          word_cnt <= w0;
          err_cnt  <= e0;
        end
      end
    end
  end

  crcchk_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_cnt    (push_cnt),
    .push_first  (res0),
    .push_second (res1),
    .pop         (pop),
    .head        (head),
    .count       (fifo_count)
  );

  // output word
  assign m_axis_tvalid = (fifo_count != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {head.errors_seen, head.words_seen, head.decoded_byte,
                          head.dataword_value};
  assign m_axis_tuser  = {head.byte_ready, head.codeword_bad};
  assign m_axis_tlast  = head.run_last;

  // checks
  `CRCCHK_ASSERT_ALWAYS(a_queue_bound, fifo_count <= 3'd4, "result queue overran")
  `CRCCHK_ASSERT_ALWAYS(a_err_le_words, err_cnt <= word_cnt, "error count passed word count")
  `CRCCHK_ASSERT_NEXT(a_hdr_clears, commit && in_hdr, held == '0 && !nib_wait, "header left bits")

endmodule
